/* design/slpd_pkg.sv */
// Shared types, constants and segment encoding functions for the serial LCD phase driver.
package slpd_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_DIGITS = 2'd1,
        FUNC_SMALL  = 2'd2,
        FUNC_SIGNED = 2'd3
    } func_t;

    localparam int unsigned TOPSIDE_GLASS_DEFAULT = 0;
    localparam int unsigned NUM_PHASES            = 4;
    localparam int unsigned WORD_W                = 16;
    localparam int unsigned TICK_W                = 13;
    localparam int unsigned FRAME_BITS            = 17;

    localparam logic [WORD_W-1:0] BLANK_BOTTOM = 16'h8000;
    localparam logic [WORD_W-1:0] BLANK_TOP    = 16'h0100;
    localparam logic [3:0]        DIGIT_BLANK  = 4'd10;
    localparam logic [14:0]       SIGNED_MAX   = 15'd18899;
    localparam logic [14:0]       SIGNED_SPLIT = 15'd188;

    typedef struct packed {
        logic [NUM_PHASES-1:0]             wr;
        logic [NUM_PHASES-1:0][WORD_W-1:0] word;
    } slpd_wr_t;

    function automatic logic [6:0] tens_seg(input logic [3:0] idx, input logic topside);
        logic [6:0] seg;
        seg = 7'h00;
        if (topside)
        begin
            case (idx)
                4'd0:    seg = 7'h7b;
                4'd1:    seg = 7'h60;
                4'd2:    seg = 7'h37;
                4'd3:    seg = 7'h75;
                4'd4:    seg = 7'h6c;
                4'd5:    seg = 7'h5d;
                4'd6:    seg = 7'h5f;
                4'd7:    seg = 7'h70;
                4'd8:    seg = 7'h7f;
                4'd9:    seg = 7'h7d;
                4'd11:   seg = 7'h11;
                default: seg = 7'h00;
            endcase
        end
        else
        begin
            case (idx)
                4'd0:    seg = 7'h6f;
                4'd1:    seg = 7'h03;
                4'd2:    seg = 7'h76;
                4'd3:    seg = 7'h57;
                4'd4:    seg = 7'h1b;
                4'd5:    seg = 7'h5d;
                4'd6:    seg = 7'h7d;
                4'd7:    seg = 7'h07;
                4'd8:    seg = 7'h7f;
                4'd9:    seg = 7'h5f;
                4'd11:   seg = 7'h44;
                default: seg = 7'h00;
            endcase
        end
        return seg;
    endfunction

    function automatic logic [6:0] ones_seg(input logic [3:0] idx, input logic topside);
        logic [6:0] seg;
        seg = 7'h00;
        if (topside)
        begin
            case (idx)
                4'd0:    seg = 7'h5f;
                4'd1:    seg = 7'h06;
                4'd2:    seg = 7'h3b;
                4'd3:    seg = 7'h2f;
                4'd4:    seg = 7'h66;
                4'd5:    seg = 7'h6d;
                4'd6:    seg = 7'h7d;
                4'd7:    seg = 7'h07;
                4'd8:    seg = 7'h7f;
                4'd9:    seg = 7'h6f;
                4'd11:   seg = 7'h0f;
                default: seg = 7'h00;
            endcase
        end
        else
        begin
            case (idx)
                4'd0:    seg = 7'h7d;
                4'd1:    seg = 7'h30;
                4'd2:    seg = 7'h6e;
                4'd3:    seg = 7'h7a;
                4'd4:    seg = 7'h33;
                4'd5:    seg = 7'h5b;
                4'd6:    seg = 7'h5f;
                4'd7:    seg = 7'h70;
                4'd8:    seg = 7'h7f;
                4'd9:    seg = 7'h7b;
                4'd11:   seg = 7'h78;
                default: seg = 7'h00;
            endcase
        end
        return seg;
    endfunction

    function automatic logic [WORD_W-1:0] digits_word(input logic hund, input logic [3:0] tens,
                                                      input logic [3:0] ones,
                                                      input logic topside);
        logic [WORD_W-1:0] w;
        if (topside)
        begin
            w = {tens_seg(tens, 1'b1), 1'b0, hund, ones_seg(ones, 1'b1)};
        end
        else
        begin
            w = {1'b0, tens_seg(tens, 1'b0), ones_seg(ones, 1'b0), hund};
        end
        return w;
    endfunction

    // Splits a byte into a hundreds flag, tens and ones, then encodes it.
    function automatic logic [WORD_W-1:0] number_word(input logic [7:0] v, input logic allow,
                                                      input logic topside);
        logic        hund;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ten_times;
        logic [3:0]  ones;
        hund = (v >= 8'd100);
        if (v >= 8'd200)
        begin
            rem = 7'(v - 8'd200);
        end
        else if (hund)
        begin
            rem = 7'(v - 8'd100);
        end
        else
        begin
            rem = v[6:0];
        end
        prod      = 15'(rem) * 15'd205;
        tens      = prod[14:11];
        ten_times = 7'(tens) * 7'd10;
        ones      = 4'(rem - ten_times);
        if ((tens == 4'd0) && !hund && allow)
        begin
            tens = DIGIT_BLANK;
        end
        return digits_word(hund, tens, ones, topside);
    endfunction

endpackage

/* design/serial_lcd_phase_driver.sv */
// Top level of the serial LCD phase driver: input register, pin sequencer and result register.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+---------------------------------------------------
//  input   | in_valid / in_ready    | func, digits, phase, numbers, allow_blank, blink
//  output  | out_valid / out_ready  | clk_pin, data_pin, latch_pin, drive_enable
//  config  | cfg_valid / cfg_ready  | cfg_data (pins_enable)
//
// Each transaction passes through the input register, then through the sequencer logic into
// the result register; one transaction per cycle is sustained while no result is stalled.
// Reset clears all control state, loads the blank pattern into the shown word and all four
// phase buffers, and sets pins_enable. A stalled result holds the sequencer and,
// once the input register is also full, in_ready drops. Config writes are always taken.
module serial_lcd_phase_driver #(
    parameter int unsigned TOPSIDE_GLASS = slpd_pkg::TOPSIDE_GLASS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic        digit_hundreds,
    input  logic [3:0]  digit_tens,
    input  logic [3:0]  digit_ones,
    input  logic [1:0]  phase,
    input  logic [7:0]  small_number,
    input  logic        allow_blank,
    input  logic [15:0] signed_number,
    input  logic        blink,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        clk_pin,
    output logic        data_pin,
    output logic        latch_pin,
    output logic        drive_enable,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import slpd_pkg::*;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_RISE  = 2'd1,
        ST_LATCH = 2'd2,
        ST_IDLE  = 2'd3
    } state_t;

    localparam logic [WORD_W-1:0] BLANK = (TOPSIDE_GLASS != 0) ? BLANK_TOP : BLANK_BOTTOM;
    localparam logic [4:0]        LAST_BIT = 5'(FRAME_BITS - 1);

    logic              in_valid_reg;
    func_t             func_reg;
    logic              hund_reg;
    logic [3:0]        tens_reg;
    logic [3:0]        ones_reg;
    logic [1:0]        phase_reg;
    logic [7:0]        small_reg;
    logic              allow_reg;
    logic [15:0]       signed_reg;
    logic              blink_reg;

    logic              pins_enable_reg;
    logic              out_valid_reg;
    logic              drive_enable_reg;

    state_t            state_reg, state_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [4:0]        bit_reg, bit_next;
    logic [1:0]        frame_reg, frame_next;
    logic              pending_reg, pending_next;
    logic [1:0]        active_reg, active_next;
    logic [WORD_W-1:0] shown_reg, shown_next;
    logic [WORD_W-1:0] pattern_reg [NUM_PHASES];
    logic [WORD_W-1:0] pattern_next [NUM_PHASES];
    logic              clk_reg, clk_next;
    logic              data_reg, data_next;
    logic              latch_reg, latch_next;

    logic              advance;
    logic              process;
    slpd_wr_t          wr;

    assign advance   = !out_valid_reg || out_ready;
    assign process   = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign clk_pin      = clk_reg;
    assign data_pin     = data_reg;
    assign latch_pin    = latch_reg;
    assign drive_enable = drive_enable_reg;

    slpd_encode #(
        .TOPSIDE_GLASS(TOPSIDE_GLASS)
    ) u_encode (
        .func          (func_reg),
        .digit_hundreds(hund_reg),
        .digit_tens    (tens_reg),
        .digit_ones    (ones_reg),
        .phase         (phase_reg),
        .small_number  (small_reg),
        .allow_blank   (allow_reg),
        .signed_number (signed_reg),
        .blink         (blink_reg),
        .wr_out        (wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg   <= func_t'(func);
            hund_reg   <= digit_hundreds;
            tens_reg   <= digit_tens;
            ones_reg   <= digit_ones;
            phase_reg  <= phase;
            small_reg  <= small_number;
            allow_reg  <= allow_blank;
            signed_reg <= signed_number;
            blink_reg  <= blink;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pins_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pins_enable_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        frame_next   = frame_reg;
        pending_next = pending_reg;
        active_next  = active_reg;
        shown_next   = shown_reg;
        clk_next     = clk_reg;
        data_next    = data_reg;
        latch_next   = latch_reg;
        for (int i = 0; i < NUM_PHASES; i++)
        begin
            pattern_next[i] = pattern_reg[i];
        end

        if (func_reg == FUNC_TICK)
        begin
            tick_next = tick_reg + 1'b1;
            if (tick_next[10:0] == '0)
            begin
                active_next  = tick_next[TICK_W-1:TICK_W-2];
                pending_next = 1'b1;
            end
            unique case (state_reg)
                ST_DATA:
                begin
                    state_next = ST_RISE;
                    clk_next   = 1'b0;
                    data_next  = bit_reg[4] ? 1'b0 : shown_reg[bit_reg[3:0]];
                    bit_next   = bit_reg + 1'b1;
                    if (bit_reg >= LAST_BIT)
                    begin
                        state_next = ST_LATCH;
                        latch_next = 1'b1;
                        bit_next   = '0;
                        if (frame_reg != 2'd3)
                        begin
                            frame_next = frame_reg + 1'b1;
                        end
                        if (pending_next)
                        begin
                            pending_next = 1'b0;
                            shown_next   = pattern_reg[active_next];
                        end
                        else if (frame_next >= 2'd2)
                        begin
                            frame_next = '0;
                            shown_next = ~shown_reg;
                        end
                    end
                end
                ST_RISE:
                begin
                    state_next = ST_DATA;
                    clk_next   = 1'b1;
                end
                ST_LATCH:
                begin
                    state_next = ST_IDLE;
                    latch_next = 1'b0;
                end
                ST_IDLE:
                begin
                    state_next = ST_DATA;
                end
                default:
                begin
                    state_next = ST_DATA;
                end
            endcase
        end
        else
        begin
            pending_next = 1'b1;
            for (int i = 0; i < NUM_PHASES; i++)
            begin
                if (wr.wr[i])
                begin
                    pattern_next[i] = wr.word[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_DATA;
            tick_reg         <= '0;
            bit_reg          <= '0;
            frame_reg        <= '0;
            pending_reg      <= 1'b0;
            active_reg       <= '0;
            shown_reg        <= BLANK;
            for (int i = 0; i < NUM_PHASES; i++)
            begin
                pattern_reg[i] <= BLANK;
            end
            clk_reg          <= 1'b0;
            data_reg         <= 1'b0;
            latch_reg        <= 1'b0;
            drive_enable_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (process)
            begin
                state_reg        <= state_next;
                tick_reg         <= tick_next;
                bit_reg          <= bit_next;
                frame_reg        <= frame_next;
                pending_reg      <= pending_next;
                active_reg       <= active_next;
                shown_reg        <= shown_next;
                for (int i = 0; i < NUM_PHASES; i++)
                begin
                    pattern_reg[i] <= pattern_next[i];
                end
                clk_reg          <= clk_next;
                data_reg         <= data_next;
                latch_reg        <= latch_next;
                drive_enable_reg <= pins_enable_reg;
            end
        end
    end

endmodule

/* design/slpd_encode.sv */
// Pattern encoder that turns a write transaction into phase buffer words and write strobes.
module slpd_encode #(
    parameter int unsigned TOPSIDE_GLASS = slpd_pkg::TOPSIDE_GLASS_DEFAULT
) (
    input  slpd_pkg::func_t  func,
    input  logic             digit_hundreds,
    input  logic [3:0]       digit_tens,
    input  logic [3:0]       digit_ones,
    input  logic [1:0]       phase,
    input  logic [7:0]       small_number,
    input  logic             allow_blank,
    input  logic [15:0]      signed_number,
    input  logic             blink,
    output slpd_pkg::slpd_wr_t wr_out
);
    import slpd_pkg::*;

    localparam logic TOP = (TOPSIDE_GLASS != 0);

    logic [14:0]       clamped;
    logic [27:0]       div_prod;
    logic [7:0]        high_part;
    logic [14:0]       high_times;
    logic [7:0]        low_part;
    logic [WORD_W-1:0] word_phase;
    logic [WORD_W-1:0] word_low;
    logic [WORD_W-1:0] word_high;
    logic [WORD_W-1:0] word_small;
    logic [WORD_W-1:0] word_empty;

    always_comb
    begin
        if (signed_number[15])
        begin
            clamped = '0;
        end
        else if (signed_number[14:0] > SIGNED_MAX)
        begin
            clamped = SIGNED_MAX;
        end
        else
        begin
            clamped = signed_number[14:0];
        end
        // The reciprocal product is exact for every value up to the clamp limit.
        div_prod   = 28'(clamped) * 28'd5243;
        high_part  = div_prod[26:19];
        high_times = 15'(high_part) * 15'd100;
        low_part   = 8'(clamped - high_times);

        word_phase = (func == FUNC_DIGITS)
                   ? digits_word(digit_hundreds, digit_tens, digit_ones, TOP)
                   : number_word(small_number, allow_blank, TOP);
        word_low   = number_word(low_part, 1'b0, TOP);
        word_high  = number_word(high_part, 1'b1, TOP);
        word_small = number_word(clamped[7:0], 1'b1, TOP);
        word_empty = digits_word(1'b0, DIGIT_BLANK, DIGIT_BLANK, TOP);

        wr_out = '0;
        case (func)
            FUNC_DIGITS, FUNC_SMALL:
            begin
                wr_out.wr[phase]   = 1'b1;
                wr_out.word[phase] = word_phase;
            end
            FUNC_SIGNED:
            begin
                wr_out.wr = '1;
                if (clamped > SIGNED_SPLIT)
                begin
                    wr_out.word[0] = word_low;
                    wr_out.word[1] = blink ? word_high : word_low;
                    wr_out.word[2] = blink ? word_low : word_high;
                    wr_out.word[3] = word_high;
                end
                else
                begin
                    wr_out.word[0] = word_small;
                    wr_out.word[1] = blink ? word_empty : word_small;
                    wr_out.word[2] = word_small;
                    wr_out.word[3] = blink ? word_empty : word_small;
                end
            end
            default:
            begin
                wr_out = '0;
            end
        endcase
    end

endmodule

/* bench/slpd_pin_checker.sv */
// Pin level predictor and result checker for the serial LCD phase driver bench.
`timescale 1ns / 100ps

module slpd_pin_checker #(
    parameter int unsigned TOPSIDE = slpd_pkg::TOPSIDE_GLASS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic        digit_hundreds,
    input  logic [3:0]  digit_tens,
    input  logic [3:0]  digit_ones,
    input  logic [1:0]  phase,
    input  logic [7:0]  small_number,
    input  logic        allow_blank,
    input  logic [15:0] signed_number,
    input  logic        blink,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        clk_pin,
    input  logic        data_pin,
    input  logic        latch_pin,
    input  logic        drive_enable,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          fail_count,
    output int          pending,
    output int          results_checked
);

    import slpd_pkg::*;

    typedef struct packed {
        logic clk_pin;
        logic data_pin;
        logic latch_pin;
        logic drive_enable;
    } pin_levels_t;

    localparam logic [83:0] TENS_BOTTOM = {7'h44, 7'h00, 7'h5f, 7'h7f, 7'h07, 7'h7d,
                                           7'h5d, 7'h1b, 7'h57, 7'h76, 7'h03, 7'h6f};
    localparam logic [83:0] TENS_TOP    = {7'h11, 7'h00, 7'h7d, 7'h7f, 7'h70, 7'h5f,
                                           7'h5d, 7'h6c, 7'h75, 7'h37, 7'h60, 7'h7b};
    localparam logic [83:0] ONES_BOTTOM = {7'h78, 7'h00, 7'h7b, 7'h7f, 7'h70, 7'h5f,
                                           7'h5b, 7'h33, 7'h7a, 7'h6e, 7'h30, 7'h7d};
    localparam logic [83:0] ONES_TOP    = {7'h0f, 7'h00, 7'h6f, 7'h7f, 7'h07, 7'h7d,
                                           7'h6d, 7'h66, 7'h2f, 7'h3b, 7'h06, 7'h5f};
    localparam logic [15:0] BLANK_WORD  = (TOPSIDE != 0) ? BLANK_TOP : BLANK_BOTTOM;

    pin_levels_t expected_pins[$];

    logic [12:0] tick_count;
    logic [1:0]  clk_state;
    int unsigned bit_index;
    logic [1:0]  frame_count;
    logic        update_pending;
    logic [1:0]  active_phase;
    logic [15:0] shown_word;
    logic [15:0] phase_words[4];
    logic        lvl_clk;
    logic        lvl_data;
    logic        lvl_latch;
    logic        pins_enable;
    int          errors = 0;
    int          checked = 0;

    function automatic logic [6:0] segments(input logic [83:0] tab, input logic [3:0] idx);
        return (idx < 4'd12) ? tab[idx*7 +: 7] : 7'h00;
    endfunction

    function automatic void store_digits(input logic hund, input logic [3:0] tens,
                                         input logic [3:0] ones, input logic [1:0] ph);
        if (TOPSIDE != 0)
        begin
            phase_words[ph] = {segments(TENS_TOP, tens), 1'b0, hund, segments(ONES_TOP, ones)};
        end
        else
        begin
            phase_words[ph] = {1'b0, segments(TENS_BOTTOM, tens), segments(ONES_BOTTOM, ones),
                               hund};
        end
        update_pending = 1'b1;
    endfunction

    function automatic void store_number(input logic [7:0] v, input logic [1:0] ph,
                                         input logic allow);
        int unsigned h;
        int unsigned t;
        int unsigned o;
        h = (v >= 8'd100) ? 1 : 0;
        t = (v / 10) % 10;
        o = v % 10;
        if (t == 0 && h == 0 && allow)
        begin
            t = 32'(DIGIT_BLANK);
        end
        store_digits(h[0], t[3:0], o[3:0], ph);
    endfunction

    function automatic void store_signed(input logic [15:0] raw, input logic blk);
        int          s;
        int unsigned val;
        logic [7:0]  lo;
        logic [7:0]  hi;
        s = $signed(raw);
        if (s > 18899)
        begin
            s = 18899;
        end
        val = (s < 0) ? 0 : s;
        if (val > 188)
        begin
            lo = 8'(val % 100);
            hi = 8'(val / 100);
            store_number(lo, 2'd0, 1'b0);
            store_number(lo, blk ? 2'd2 : 2'd1, 1'b0);
            store_number(hi, 2'd3, 1'b1);
            store_number(hi, blk ? 2'd1 : 2'd2, 1'b1);
        end
        else
        begin
            store_number(8'(val), 2'd0, 1'b1);
            store_number(8'(val), 2'd2, 1'b1);
            if (blk)
            begin
                store_digits(1'b0, DIGIT_BLANK, DIGIT_BLANK, 2'd1);
                store_digits(1'b0, DIGIT_BLANK, DIGIT_BLANK, 2'd3);
            end
            else
            begin
                store_number(8'(val), 2'd1, 1'b1);
                store_number(8'(val), 2'd3, 1'b1);
            end
        end
    endfunction

    function automatic void advance_tick();
        tick_count = tick_count + 13'd1;
        if (tick_count[10:0] == 11'd0)
        begin
            active_phase   = tick_count[12:11];
            update_pending = 1'b1;
        end
        case (clk_state)
            2'd0:
            begin
                clk_state = 2'd1;
                lvl_clk   = 1'b0;
                lvl_data  = (bit_index < 16) ? shown_word[bit_index] : 1'b0;
                bit_index++;
                if (bit_index >= FRAME_BITS)
                begin
                    clk_state = 2'd2;
                    lvl_latch = 1'b1;
                    bit_index = 0;
                    if (frame_count < 2'd3)
                    begin
                        frame_count++;
                    end
                    if (update_pending)
                    begin
                        update_pending = 1'b0;
                        shown_word     = phase_words[active_phase];
                    end
                    else if (frame_count >= 2'd2)
                    begin
                        frame_count = 2'd0;
                        shown_word  = ~shown_word;
                    end
                end
            end
            2'd1:
            begin
                clk_state = 2'd0;
                lvl_clk   = 1'b1;
            end
            2'd2:
            begin
                clk_state = 2'd3;
                lvl_latch = 1'b0;
            end
            default:
            begin
                clk_state = 2'd0;
            end
        endcase
    endfunction

    task automatic compare_pin(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0b, got %0b", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pin_levels_t want;
        if (!rst_n)
        begin
            tick_count     = '0;
            clk_state      = 2'd0;
            bit_index      = 0;
            frame_count    = 2'd0;
            update_pending = 1'b0;
            active_phase   = 2'd0;
            shown_word     = BLANK_WORD;
            for (int i = 0; i < 4; i++)
            begin
                phase_words[i] = BLANK_WORD;
            end
            lvl_clk     = 1'b0;
            lvl_data    = 1'b0;
            lvl_latch   = 1'b0;
            pins_enable = 1'b1;
            expected_pins.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pins_enable = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (expected_pins.size() == 0)
                begin
                    errors++;
                    $error("unexpected result transaction: clk %0b data %0b latch %0b en %0b",
                           clk_pin, data_pin, latch_pin, drive_enable);
                end
                else
                begin
                    want = expected_pins.pop_front();
                    compare_pin("clk_pin", want.clk_pin, clk_pin);
                    compare_pin("data_pin", want.data_pin, data_pin);
                    compare_pin("latch_pin", want.latch_pin, latch_pin);
                    compare_pin("drive_enable", want.drive_enable, drive_enable);
                    checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                case (func)
                    FUNC_TICK:   advance_tick();
                    FUNC_DIGITS: store_digits(digit_hundreds, digit_tens, digit_ones, phase);
                    FUNC_SMALL:  store_number(small_number, phase, allow_blank);
                    default:     store_signed(signed_number, blink);
                endcase
                want.clk_pin      = lvl_clk;
                want.data_pin     = lvl_data;
                want.latch_pin    = lvl_latch;
                want.drive_enable = pins_enable;
                expected_pins.push_back(want);
            end
            pending <= expected_pins.size();
        end
    end

    always @(posedge clk)
    begin
        fail_count      <= errors;
        results_checked <= checked;
    end

endmodule

/* bench/tb_serial_lcd_phase_driver.sv */
// Stimulus and verdict for the serial LCD phase driver, with the pin checker alongside.
`timescale 1ns / 100ps

module tb_serial_lcd_phase_driver;

    import slpd_pkg::*;

    localparam int unsigned GLASS = TOPSIDE_GLASS_DEFAULT;

    typedef struct {
        func_t       func;
        logic        hund;
        logic [3:0]  tens;
        logic [3:0]  ones;
        logic [1:0]  ph;
        logic [7:0]  small_val;
        logic        allow;
        logic [15:0] snum;
        logic        blk;
    } lcd_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = FUNC_TICK;
    logic        digit_hundreds = 1'b0;
    logic [3:0]  digit_tens = '0;
    logic [3:0]  digit_ones = '0;
    logic [1:0]  phase = '0;
    logic [7:0]  small_number = '0;
    logic        allow_blank = 1'b0;
    logic [15:0] signed_number = '0;
    logic        blink = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic        clk_pin;
    logic        data_pin;
    logic        latch_pin;
    logic        drive_enable;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b1;

    int fail_count;
    int pending;
    int results_checked;

    int items_sent[4] = '{0, 0, 0, 0};
    int enable_writes = 0;
    int leftovers = 0;
    logic tx_calm = 1'b0;
    int tx_mode_left = 100;
    logic rx_calm = 1'b0;
    int rx_mode_left = 200;
    int rx_hold = 0;

    serial_lcd_phase_driver #(.TOPSIDE_GLASS(GLASS)) u_dut (.*);

    slpd_pin_checker #(.TOPSIDE(GLASS)) u_checker (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #6_000_000;
        $display("** serial_lcd_phase_driver: FAILED **");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_calm      = !rx_calm;
            rx_mode_left = $urandom_range(50, 400);
        end
        else
        begin
            rx_mode_left--;
        end
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!rx_calm)
            begin
                rx_hold = pick_gap();
            end
        end
    end

    function automatic lcd_req_t req_of(input func_t f, input logic h, input logic [3:0] t,
                                        input logic [3:0] o, input logic [1:0] ph,
                                        input logic [7:0] sm, input logic allow,
                                        input logic [15:0] sn, input logic blk);
        lcd_req_t r;
        r.func      = f;
        r.hund      = h;
        r.tens      = t;
        r.ones      = o;
        r.ph        = ph;
        r.small_val = sm;
        r.allow     = allow;
        r.snum      = sn;
        r.blk       = blk;
        return r;
    endfunction

    function automatic lcd_req_t random_req(input int tick_pct);
        lcd_req_t r;
        r.func  = ($urandom_range(0, 99) < tick_pct) ? FUNC_TICK : func_t'($urandom_range(1, 3));
        r.hund  = 1'($urandom_range(0, 1));
        r.tens  = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 11))
                                               : 4'($urandom_range(12, 15));
        r.ones  = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 11))
                                               : 4'($urandom_range(12, 15));
        r.ph        = 2'($urandom_range(0, 3));
        r.small_val = 8'($urandom_range(0, 255));
        r.allow     = 1'($urandom_range(0, 1));
        r.blk       = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0:       r.snum = 16'($urandom);
            1:       r.snum = 16'($urandom_range(0, 188));
            2:       r.snum = 16'($urandom_range(189, 18899));
            3:       r.snum = 16'($urandom_range(18900, 32767));
            4:       r.snum = 16'(-$urandom_range(1, 32768));
            default: r.snum = 16'($urandom_range(180, 200));
        endcase
        return r;
    endfunction

    task automatic push_item(input lcd_req_t r);
        int gap;
        in_valid       <= 1'b1;
        func           <= r.func;
        digit_hundreds <= r.hund;
        digit_tens     <= r.tens;
        digit_ones     <= r.ones;
        phase          <= r.ph;
        small_number   <= r.small_val;
        allow_blank    <= r.allow;
        signed_number  <= r.snum;
        blink          <= r.blk;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        items_sent[r.func]++;
        tx_mode_left--;
        if (tx_mode_left <= 0)
        begin
            tx_calm      = !tx_calm;
            tx_mode_left = $urandom_range(30, 200);
        end
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (pending != 0 && guard < 20000);
        if (pending != 0)
        begin
            leftovers += pending;
            $error("%0d expected results never arrived", pending);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_enable(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        enable_writes++;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_enable(1'b1);

        push_item(req_of(FUNC_DIGITS, 1'b1, 4'd0, 4'd11, 2'd0, 8'd0, 1'b0, 16'd0, 1'b0));
        push_item(req_of(FUNC_DIGITS, 1'b0, 4'd11, 4'd15, 2'd3, 8'd0, 1'b1, 16'd0, 1'b0));
        push_item(req_of(FUNC_DIGITS, 1'b1, 4'd15, 4'd12, 2'd1, 8'hff, 1'b0, 16'hffff, 1'b1));
        push_item(req_of(FUNC_DIGITS, 1'b0, 4'd10, 4'd10, 2'd2, 8'd0, 1'b0, 16'd0, 1'b0));
        push_item(req_of(FUNC_TICK, 1'b1, 4'd15, 4'd15, 2'd3, 8'hff, 1'b1, 16'hffff, 1'b1));
        push_item(req_of(FUNC_SMALL, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b1, 16'd0, 1'b0));
        push_item(req_of(FUNC_SMALL, 1'b0, 4'd0, 4'd0, 2'd1, 8'd0, 1'b0, 16'd0, 1'b0));
        push_item(req_of(FUNC_SMALL, 1'b0, 4'd0, 4'd0, 2'd2, 8'd255, 1'b1, 16'd0, 1'b0));
        push_item(req_of(FUNC_SMALL, 1'b0, 4'd0, 4'd0, 2'd3, 8'd100, 1'b1, 16'd0, 1'b0));
        push_item(req_of(FUNC_SMALL, 1'b0, 4'd0, 4'd0, 2'd0, 8'd5, 1'b1, 16'd0, 1'b0));
        push_item(req_of(FUNC_SMALL, 1'b0, 4'd0, 4'd0, 2'd1, 8'd99, 1'b1, 16'd0, 1'b0));
        push_item(req_of(FUNC_TICK, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'd0, 1'b0));
        push_item(req_of(FUNC_SIGNED, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'h8000, 1'b0));
        push_item(req_of(FUNC_SIGNED, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'hffff, 1'b1));
        push_item(req_of(FUNC_SIGNED, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'd0, 1'b0));
        push_item(req_of(FUNC_SIGNED, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'd188, 1'b0));
        push_item(req_of(FUNC_SIGNED, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'd188, 1'b1));
        push_item(req_of(FUNC_SIGNED, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'd189, 1'b0));
        push_item(req_of(FUNC_SIGNED, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'd18899, 1'b1));
        push_item(req_of(FUNC_SIGNED, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'd18900, 1'b0));
        push_item(req_of(FUNC_SIGNED, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'h7fff, 1'b1));
        push_item(req_of(FUNC_SIGNED, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'd5000, 1'b0));
        for (int i = 0; i < 3; i++)
        begin
            push_item(req_of(FUNC_TICK, 1'b0, 4'd0, 4'd0, 2'd0, 8'd0, 1'b0, 16'd0, 1'b0));
        end

        settle();
        write_enable(1'b0);
        for (int i = 0; i < 275; i++)
        begin
            push_item(random_req(70));
        end

        settle();
        write_enable(1'b1);
        for (int i = 0; i < 275; i++)
        begin
            // Hold the sender off until every outstanding result has drained.
            if (i == 140)
            begin
                settle();
            end
            push_item(random_req(92));
        end
        settle();

        $display("Run covered %0d ticks, %0d digit writes, %0d small and %0d signed number writes",
                 items_sent[FUNC_TICK], items_sent[FUNC_DIGITS], items_sent[FUNC_SMALL],
                 items_sent[FUNC_SIGNED]);
        $display("with %0d results checked and %0d pin enable writes.",
                 results_checked, enable_writes);
        if (fail_count == 0 && leftovers == 0)
        begin
            $display("** serial_lcd_phase_driver: PASSED **");
        end
        else
        begin
            $display("** serial_lcd_phase_driver: FAILED **");
        end
        $finish;
    end

endmodule
